@@ hdl/mbet_pkg.sv @@
// Shared types, constants and helpers for the escape-time unit.
// Used by mbet_cell and mandelbrot_escape_time_unit; no dependencies.
package mbet_pkg;

    localparam int Q_W        = 36;   // Q8.28 iterate / point width
    localparam int FRAC_BITS  = 28;
    localparam int CNT_W      = 17;
    localparam int RING_CELLS = 4;

    localparam logic signed [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
    localparam logic signed [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

    typedef enum logic [2:0] {
        REG_REAL_MIN  = 3'd0,
        REG_IMAG_MIN  = 3'd1,
        REG_REAL_STEP = 3'd2,
        REG_IMAG_STEP = 3'd3,
        REG_MAX_ITER  = 3'd4
    } mbet_reg_t;

    // One pixel in flight around the ring
    typedef struct packed {
        logic                    valid;
        logic                    done;
        logic signed [Q_W-1:0]   zr;
        logic signed [Q_W-1:0]   zi;
        logic signed [Q_W-1:0]   cr;
        logic signed [Q_W-1:0]   ci;
        logic [CNT_W-1:0]        count;
    } mbet_tok_t;

    // Clamp a wide signed sum into Q8.28
    function automatic logic signed [Q_W-1:0] sat_q(input logic signed [43:0] v);
        logic signed [Q_W-1:0] res;
        if (v[43:Q_W-1] == '0 || v[43:Q_W-1] == '1)
        begin
            res = v[Q_W-1:0];
        end
        else if (v[43])
        begin
            res = Q_MIN;
        end
        else
        begin
            res = Q_MAX;
        end
        return res;
    endfunction

    // |v| >= 2.0 ; note -2.0 itself counts as out
    function automatic logic abs_ge_two(input logic signed [Q_W-1:0] v);
        logic res;
        if (v[Q_W-1])
        begin
            res = !((&v[Q_W-1:FRAC_BITS+1]) && (|v[FRAC_BITS:0]));
        end
        else
        begin
            res = |v[Q_W-2:FRAC_BITS+1];
        end
        return res;
    endfunction

endpackage

@@ hdl/mbet_cell.sv @@
// One iteration cell of the ring: squares/cross product, then z update and escape test.
// Depends on mbet_pkg.
module mbet_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [16:0]                 max_iter,
    input  mbet_pkg::mbet_tok_t         tok_in,
    output mbet_pkg::mbet_tok_t         tok_out
);
    import mbet_pkg::*;

    // stage A: products of the incoming iterate
    logic [Q_W-1:0]        abs_r;
    logic [Q_W-1:0]        abs_i;
    logic [28:0]           mag_r;
    logic [28:0]           mag_i;
    logic [57:0]           sqp_r;
    logic [57:0]           sqp_i;
    logic signed [29:0]    fr;
    logic signed [29:0]    fi;
    logic signed [59:0]    xp;

    mbet_tok_t             tok_a_reg;
    logic [29:0]           sq_r_reg;
    logic [29:0]           sq_i_reg;
    logic signed [32:0]    cross_reg;

    // stage B: update
    logic [30:0]           sq_sum;
    logic signed [43:0]    nr_w;
    logic signed [43:0]    ni_w;
    logic signed [Q_W-1:0] nr;
    logic signed [Q_W-1:0] ni;
    logic [CNT_W-1:0]      cnt_inc;
    mbet_tok_t             tok_b;
    mbet_tok_t             tok_out_reg;

    // live iterates are below 2.0 in magnitude, so 29 magnitude bits suffice
    always_comb
    begin
        abs_r = tok_in.zr[Q_W-1] ? (~tok_in.zr + 36'd1) : tok_in.zr;
        abs_i = tok_in.zi[Q_W-1] ? (~tok_in.zi + 36'd1) : tok_in.zi;
        mag_r = abs_r[28:0];
        mag_i = abs_i[28:0];
        sqp_r = mag_r * mag_r;
        sqp_i = mag_i * mag_i;
        fr    = tok_in.zr[29:0];
        fi    = tok_in.zi[29:0];
        xp    = fr * fi;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_a_reg <= '0;
        end
        else
        begin
            tok_a_reg <= tok_in;
        end
    end

    // floor(2*zr*zi / 2^28) is the arithmetic shift by 27
    always_ff @(posedge clk)
    begin
        sq_r_reg  <= sqp_r[57:28];
        sq_i_reg  <= sqp_i[57:28];
        cross_reg <= xp[59:27];
    end

    always_comb
    begin
        sq_sum  = {1'b0, sq_r_reg} + {1'b0, sq_i_reg};
        nr_w    = $signed({14'd0, sq_r_reg}) - $signed({14'd0, sq_i_reg})
                + $signed({{8{tok_a_reg.cr[Q_W-1]}}, tok_a_reg.cr});
        ni_w    = $signed({{11{cross_reg[32]}}, cross_reg})
                + $signed({{8{tok_a_reg.ci[Q_W-1]}}, tok_a_reg.ci});
        nr      = sat_q(nr_w);
        ni      = sat_q(ni_w);
        cnt_inc = tok_a_reg.count + 17'd1;

        tok_b = tok_a_reg;
        if (tok_a_reg.valid && !tok_a_reg.done)
        begin
            // squares of the current z close the previous escape test
            priority if (tok_a_reg.count != '0 && sq_sum[30])
            begin
                tok_b.done = 1'b1;
            end
            else
            begin
                tok_b.zr    = nr;
                tok_b.zi    = ni;
                tok_b.count = cnt_inc;
                tok_b.done  = abs_ge_two(nr) || abs_ge_two(ni) || (cnt_inc >= max_iter);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_out_reg <= '0;
        end
        else
        begin
            tok_out_reg <= tok_b;
        end
    end

    assign tok_out = tok_out_reg;

endmodule

@@ hdl/mandelbrot_escape_time_unit.sv @@
// Latency: setup through S_MUL, S_SUM and S_LAUNCH, then the iterations in the cell ring, and
// the trip of a finished pixel through the rest of the ring to the ring exit.
// Throughput: one pixel at a time; the iteration recurrence runs through each cell's
// multiply and update registers, and a pixel that never escapes runs max_iter iterations.
// A new request is taken while the previous result waits in the output register.
// Reset: async active low; config returns to -2.0, -2.0, 2^-9, 2^-9, 100000.
module mandelbrot_escape_time_unit #(
    parameter int MAX_DIM = 2048
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [31:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [10:0] column,
    input  logic [10:0] row,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [16:0] iterations
);
    import mbet_pkg::*;

    localparam logic [16:0] ROW_LAST = 17'(MAX_DIM - 1);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_MUL    = 5'b00010,
        S_SUM    = 5'b00100,
        S_LAUNCH = 5'b01000,
        S_RUN    = 5'b10000
    } state_t;

    state_t                state_reg;
    state_t                state_next;

    logic signed [31:0]    real_min_reg;
    logic signed [31:0]    imag_min_reg;
    logic [30:0]           real_step_reg;
    logic [30:0]           imag_step_reg;
    logic [16:0]           max_iter_reg;

    logic [10:0]           col_reg;
    logic [10:0]           row_reg;
    logic [10:0]           row_lim;
    logic [41:0]           prod_r_reg;
    logic [41:0]           prod_i_reg;
    logic signed [43:0]    sum_r;
    logic signed [43:0]    sum_i;
    logic signed [Q_W-1:0] cr_reg;
    logic signed [Q_W-1:0] ci_reg;

    logic                  out_valid_reg;
    logic [16:0]           iterations_reg;

    mbet_tok_t             link [1:RING_CELLS];
    mbet_tok_t             ring_in;
    mbet_tok_t             launch_tok;
    mbet_tok_t             back_tok;
    logic                  capture;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            real_min_reg  <= -32'sd536870912;
            imag_min_reg  <= -32'sd536870912;
            real_step_reg <= 31'd524288;
            imag_step_reg <= 31'd524288;
            max_iter_reg  <= 17'd100000;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_REAL_MIN:  real_min_reg  <= cfg_wdata;
                REG_IMAG_MIN:  imag_min_reg  <= cfg_wdata;
                REG_REAL_STEP: real_step_reg <= cfg_wdata[30:0];
                REG_IMAG_STEP: imag_step_reg <= cfg_wdata[30:0];
                REG_MAX_ITER:  max_iter_reg  <= cfg_wdata[16:0];
                default:       ;
            endcase
        end
    end

    assign row_lim = ({6'd0, row} > ROW_LAST) ? ROW_LAST[10:0] : row;

    // point mapping: request regs, step products, then saturated sum
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            col_reg <= column;
            row_reg <= row_lim;
        end
        prod_r_reg <= col_reg * real_step_reg;
        prod_i_reg <= row_reg * imag_step_reg;
        cr_reg     <= sat_q(sum_r);
        ci_reg     <= sat_q(sum_i);
    end

    assign sum_r = $signed({{12{real_min_reg[31]}}, real_min_reg}) + $signed({2'b00, prod_r_reg});
    assign sum_i = $signed({{12{imag_min_reg[31]}}, imag_min_reg}) + $signed({2'b00, prod_i_reg});

    // ring of iteration cells
    always_comb
    begin
        launch_tok       = '0;
        launch_tok.valid = 1'b1;
        launch_tok.done  = (max_iter_reg == '0);
        launch_tok.cr    = cr_reg;
        launch_tok.ci    = ci_reg;

        capture = link[RING_CELLS].valid && link[RING_CELLS].done
                  && (!out_valid_reg || out_ready);
        back_tok = link[RING_CELLS];
        if (capture)
        begin
            back_tok.valid = 1'b0;
        end
        ring_in = (state_reg == S_LAUNCH) ? launch_tok : back_tok;
    end

    for (genvar g = 0; g < RING_CELLS; g++)
    begin : g_ring
        mbet_tok_t tok_into;
        if (g == 0)
        begin : g_head
            assign tok_into = ring_in;
        end
        else
        begin : g_body
            assign tok_into = link[g];
        end
        mbet_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .max_iter (max_iter_reg),
            .tok_in   (tok_into),
            .tok_out  (link[g+1])
        );
    end

    // sequencing
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (in_valid) state_next = S_MUL;
            S_MUL:    state_next = S_SUM;
            S_SUM:    state_next = S_LAUNCH;
            S_LAUNCH: state_next = S_RUN;
            S_RUN:    if (capture) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (capture)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            iterations_reg <= link[RING_CELLS].count;
        end
    end

    assign in_ready   = (state_reg == S_IDLE);
    assign out_valid  = out_valid_reg;
    assign iterations = iterations_reg;

endmodule

@@ verif/mandelbrot_escape_time_unit_tb.sv @@
`timescale 1ns / 100ps
// Self-checking bench for mandelbrot_escape_time_unit: directed pixel table, then random windows.
// Depends on hdl/mbet_pkg.sv and hdl/mandelbrot_escape_time_unit.sv.
module mandelbrot_escape_time_unit_tb;
    import mbet_pkg::*;

    localparam int MAX_DIM = 2048;
    localparam longint TWO_Q = longint'(1) << 29;
    localparam longint FOUR_Q = longint'(1) << 30;

    typedef struct {
        bit          is_write;
        mbet_reg_t   target;
        logic [31:0] wdata;
        logic [10:0] col;
        logic [10:0] rw;
        bit          typed;
        logic [16:0] want;
    } plan_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_addr;
    logic [31:0] cfg_wdata;
    logic        in_valid;
    logic        in_ready;
    logic [10:0] column;
    logic [10:0] row;
    logic        out_valid;
    logic        out_ready;
    logic [16:0] iterations;

    // shadow of the window and limit registers
    logic signed [31:0] win_real_min = -32'sd536870912;
    logic signed [31:0] win_imag_min = -32'sd536870912;
    logic [30:0]        win_real_step = 31'd524288;
    logic [30:0]        win_imag_step = 31'd524288;
    logic [16:0]        iter_limit = 17'd100000;

    logic [16:0] pending_counts[$];
    logic [16:0] oldest_count;
    plan_row_t   plan[$];
    bit          gaps_on;
    int          failures = 0;

    mandelbrot_escape_time_unit #(
        .MAX_DIM(MAX_DIM)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_addr(cfg_addr),
        .cfg_wdata(cfg_wdata),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .column(column),
        .row(row),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .iterations(iterations)
    );

    always #2 clk = ~clk;

    function automatic longint clamp_q(input longint v);
        if (v > longint'(Q_MAX))
        begin
            return longint'(Q_MAX);
        end
        if (v < longint'(Q_MIN))
        begin
            return longint'(Q_MIN);
        end
        return v;
    endfunction

    function automatic longint abs_q(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    // only valid for |a| < 2.0
    function automatic longint square_q(input longint a);
        return (abs_q(a) * abs_q(a)) >>> FRAC_BITS;
    endfunction

    function automatic logic [16:0] escape_count(input logic [10:0] col, input logic [10:0] rw);
        longint      cr;
        longint      ci;
        longint      zr;
        longint      zi;
        longint      nr;
        longint      ni;
        longint      rclamp;
        int unsigned n;
        bit          gone;
        rclamp = (rw > MAX_DIM - 1) ? longint'(MAX_DIM - 1) : longint'(rw);
        cr = clamp_q(longint'(win_real_min) + longint'(col) * longint'(win_real_step));
        ci = clamp_q(longint'(win_imag_min) + rclamp * longint'(win_imag_step));
        zr = 0;
        zi = 0;
        n = 0;
        gone = 1'b0;
        while (!gone && n < iter_limit)
        begin
            nr = clamp_q(square_q(zr) - square_q(zi) + cr);
            // 2*zr*zi / 2^28, floored
            ni = clamp_q(((zr * zi) >>> (FRAC_BITS - 1)) + ci);
            zr = nr;
            zi = ni;
            gone = abs_q(zr) >= TWO_Q || abs_q(zi) >= TWO_Q ||
                   square_q(zr) + square_q(zi) >= FOUR_Q;
            n++;
        end
        return n[16:0];
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    task automatic wait_drained();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_counts.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_reg(input mbet_reg_t idx, input logic [31:0] data);
        wait_drained();
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_addr = idx;
        cfg_wdata = data;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            REG_REAL_MIN:  win_real_min = data;
            REG_IMAG_MIN:  win_imag_min = data;
            REG_REAL_STEP: win_real_step = data[30:0];
            REG_IMAG_STEP: win_imag_step = data[30:0];
            REG_MAX_ITER:  iter_limit = data[16:0];
            default: ;
        endcase
    endtask

    // starts at the negedge after the previous request was taken
    task automatic send_pixel(input logic [10:0] col, input logic [10:0] rw,
                              input logic [16:0] count);
        int gap;
        gap = gaps_on ? pick_gap() : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        column = col;
        row = rw;
        do
            @(posedge clk);
        while (!in_ready);
        pending_counts.push_back(count);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_counts.size() == 0)
            begin
                $display("%0t ns: result with nothing pending, iterations %0d", $time, iterations);
                failures++;
            end
            else
            begin
                oldest_count = pending_counts.pop_front();
                if (iterations !== oldest_count)
                begin
                    $display("%0t ns: iterations expected %0d, got %0d",
                             $time, oldest_count, iterations);
                    failures++;
                end
            end
        end
    end

    initial
    begin
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (gaps_on && $urandom_range(0, 7) == 0)
            begin
                stall = pick_gap();
                out_ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready = 1'b1;
        end
    end

    initial
    begin
        #20_000_000;
        $display("mandelbrot_escape_time_unit: mismatch");
        $finish;
    end

    initial
    begin
        int          k;
        int          phase;
        logic [10:0] col;
        logic [10:0] rw;
        logic [31:0] word;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = REG_REAL_MIN;
        cfg_wdata = '0;
        in_valid = 1'b0;
        column = '0;
        row = '0;
        gaps_on = 1'b1;
        plan = '{
            // reset window spans -2..2 on both axes, limit 100000
            '{1'b0, REG_REAL_MIN, 32'd0, 11'd0, 11'd0, 1'b1, 17'd1},
            '{1'b0, REG_REAL_MIN, 32'd0, 11'd2047, 11'd2047, 1'b1, 17'd1},
            '{1'b0, REG_REAL_MIN, 32'd0, 11'd1024, 11'd1024, 1'b1, 17'd100000},
            '{1'b0, REG_REAL_MIN, 32'd0, 11'd1280, 11'd1280, 1'b0, 17'd0},
            '{1'b0, REG_REAL_MIN, 32'd0, 11'd1536, 11'd1024, 1'b0, 17'd0},
            '{1'b0, REG_REAL_MIN, 32'd0, 11'd1024, 11'd0, 1'b0, 17'd0},
            // zero limit runs no iteration
            '{1'b1, REG_MAX_ITER, 32'd0, 11'd0, 11'd0, 1'b0, 17'd0},
            '{1'b0, REG_REAL_MIN, 32'd0, 11'd1024, 11'd1024, 1'b1, 17'd0},
            '{1'b0, REG_REAL_MIN, 32'd0, 11'd2047, 11'd0, 1'b1, 17'd0},
            '{1'b1, REG_MAX_ITER, 32'd1, 11'd0, 11'd0, 1'b0, 17'd0},
            '{1'b0, REG_REAL_MIN, 32'd0, 11'd1024, 11'd1024, 1'b1, 17'd1},
            '{1'b0, REG_REAL_MIN, 32'd0, 11'd0, 11'd2047, 1'b1, 17'd1},
            // far-out window: c saturates, escapes at once
            '{1'b1, REG_REAL_MIN, 32'h7FFF_FFFF, 11'd0, 11'd0, 1'b0, 17'd0},
            '{1'b1, REG_REAL_STEP, 32'h7FFF_FFFF, 11'd0, 11'd0, 1'b0, 17'd0},
            '{1'b1, REG_IMAG_MIN, 32'h8000_0000, 11'd0, 11'd0, 1'b0, 17'd0},
            '{1'b1, REG_IMAG_STEP, 32'hFFFF_FFFF, 11'd0, 11'd0, 1'b0, 17'd0},
            '{1'b1, REG_MAX_ITER, 32'd131071, 11'd0, 11'd0, 1'b0, 17'd0},
            '{1'b0, REG_REAL_MIN, 32'd0, 11'd2047, 11'd0, 1'b1, 17'd1},
            '{1'b0, REG_REAL_MIN, 32'd0, 11'd0, 11'd2047, 1'b1, 17'd1},
            '{1'b0, REG_REAL_MIN, 32'd0, 11'd2047, 11'd2047, 1'b1, 17'd1},
            // zero steps pin every pixel to the window corner
            '{1'b1, REG_REAL_STEP, 32'd0, 11'd0, 11'd0, 1'b0, 17'd0},
            '{1'b1, REG_IMAG_STEP, 32'd0, 11'd0, 11'd0, 1'b0, 17'd0},
            '{1'b1, REG_REAL_MIN, 32'h1000_0000, 11'd0, 11'd0, 1'b0, 17'd0},
            '{1'b1, REG_IMAG_MIN, 32'd0, 11'd0, 11'd0, 1'b0, 17'd0},
            '{1'b0, REG_REAL_MIN, 32'd0, 11'd555, 11'd1234, 1'b0, 17'd0},
            '{1'b1, REG_REAL_MIN, 32'h8000_0000, 11'd0, 11'd0, 1'b0, 17'd0},
            '{1'b0, REG_REAL_MIN, 32'd0, 11'd2047, 11'd2047, 1'b1, 17'd1},
            '{1'b1, REG_REAL_MIN, 32'd0, 11'd0, 11'd0, 1'b0, 17'd0},
            '{1'b1, REG_IMAG_MIN, 32'h7FFF_FFFF, 11'd0, 11'd0, 1'b0, 17'd0},
            '{1'b0, REG_REAL_MIN, 32'd0, 11'd0, 11'd0, 1'b1, 17'd1},
            // c = 0 under the highest limit the counter holds
            '{1'b1, REG_IMAG_MIN, 32'd0, 11'd0, 11'd0, 1'b0, 17'd0},
            '{1'b0, REG_REAL_MIN, 32'd0, 11'd1365, 11'd682, 1'b1, 17'd131071}
        };
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (plan[k])
        begin
            if (plan[k].is_write)
            begin
                write_reg(plan[k].target, plan[k].wdata);
            end
            else
            begin
                send_pixel(plan[k].col, plan[k].rw,
                           plan[k].typed ? plan[k].want : escape_count(plan[k].col, plan[k].rw));
            end
        end

        // random windows around the set, with an occasional wild one
        for (phase = 0; phase < 5; phase++)
        begin
            gaps_on = (phase != 2);
            k = $urandom_range(0, 19);
            if (k == 0)
            begin
                word = 32'd0;
            end
            else if (k < 4)
            begin
                word = $urandom_range(400, 2500);
            end
            else
            begin
                word = $urandom_range(1, 300);
            end
            write_reg(REG_MAX_ITER, word);
            word = ($urandom_range(0, 4) == 0) ? $urandom()
                 : 32'(int'($urandom_range(0, 805306368)) - 671088640);
            write_reg(REG_REAL_MIN, word);
            word = ($urandom_range(0, 4) == 0) ? $urandom()
                 : 32'(int'($urandom_range(0, 536870912)) - 402653184);
            write_reg(REG_IMAG_MIN, word);
            word = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 524288);
            write_reg(REG_REAL_STEP, word);
            word = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 524288);
            write_reg(REG_IMAG_STEP, word);
            for (k = 0; k < 20; k++)
            begin
                col = $urandom_range(0, 2047);
                rw = $urandom_range(0, 2047);
                send_pixel(col, rw, escape_count(col, rw));
            end
        end

        wait_drained();
        repeat (2 * RING_CELLS + 16) @(posedge clk);
        if (failures == 0)
        begin
            $display("mandelbrot_escape_time_unit: match");
        end
        else
        begin
            $display("mandelbrot_escape_time_unit: mismatch");
        end
        $finish;
    end

endmodule
